// ----- src/htfac_pkg.sv -----
package htfac_pkg;

    localparam int LEN_W   = 16;
    localparam int MCS_W   = 5;
    localparam int TIME_W  = 17;
    localparam int SYM_W   = 10;
    localparam int BPS_W   = 12;
    localparam int NUM_W   = 20;
    localparam int REM_W   = BPS_W;
    localparam int QUO_W   = 15;
    localparam int X_W     = 19;
    localparam int PROD_W  = 38;

    localparam logic [NUM_W-1:0]  PLCP_BITS   = NUM_W'(22);
    localparam logic [TIME_W-1:0] PREAMBLE_US = TIME_W'(32);
    localparam logic [TIME_W-1:0] LTF_US      = TIME_W'(4);
    localparam logic [X_W-1:0]    SGI_ROUND   = X_W'(4);
    // ceil(2^21 / 5), exact division by 5 for x below 699050
    localparam logic [PROD_W-1:0] DIV5_RECIP  = PROD_W'(419431);
    localparam int                DIV5_SHIFT  = 21;
    localparam logic [TIME_W-1:0] AIRTIME_MAX = TIME_W'(80700);
    localparam logic [TIME_W-1:0] AIRTIME_MIN = TIME_W'(40);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] work;
        logic [BPS_W-1:0] divisor;
        logic             sgi;
        logic [1:0]       streams_m1;
    } t_div_word;

    // data bits per symbol for one stream
    function automatic logic [SYM_W-1:0] sym_bits(input logic [2:0] mod, input logic wide);
        logic [SYM_W-1:0] v;
        begin
            unique case (mod)
                3'd0: v = wide ? SYM_W'(54)  : SYM_W'(26);
                3'd1: v = wide ? SYM_W'(108) : SYM_W'(52);
                3'd2: v = wide ? SYM_W'(162) : SYM_W'(78);
                3'd3: v = wide ? SYM_W'(216) : SYM_W'(104);
                3'd4: v = wide ? SYM_W'(324) : SYM_W'(156);
                3'd5: v = wide ? SYM_W'(432) : SYM_W'(208);
                3'd6: v = wide ? SYM_W'(486) : SYM_W'(234);
                3'd7: v = wide ? SYM_W'(540) : SYM_W'(260);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- src/htfac_prep.sv -----
module htfac_prep (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [15:0]                i_pkt_length,
    input  logic [4:0]                 i_mcs_index,
    input  logic                       i_channel_width,
    input  logic                       i_short_guard_interval,
    output logic                       o_stall,
    output logic                       o_valid,
    output htfac_pkg::t_div_word       o_word,
    input  logic                       i_stall
);
    import htfac_pkg::*;

    logic             r_valid;
    t_div_word        r_word;
    t_div_word        n_word;
    logic [SYM_W-1:0] w_sym;
    logic [2:0]       w_streams;
    logic [BPS_W-1:0] w_bps;

    assign o_stall = r_valid & i_stall;

    always_comb begin
        w_sym     = sym_bits(i_mcs_index[2:0], i_channel_width);
        w_streams = {1'b0, i_mcs_index[4:3]} + 3'd1;
        w_bps     = {2'b00, w_sym} * BPS_W'(w_streams);
        n_word.rem        = '0;
        // ceiling division: dividend is data bits plus divisor minus one
        n_word.work       = {1'b0, i_pkt_length, 3'b000} + PLCP_BITS
                          + NUM_W'(w_bps) - NUM_W'(1);
        n_word.divisor    = w_bps;
        n_word.sgi        = i_short_guard_interval;
        n_word.streams_m1 = i_mcs_index[4:3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- src/htfac_div_cell.sv -----
module htfac_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  htfac_pkg::t_div_word i_word,
    output logic                 o_stall,
    output logic                 o_valid,
    output htfac_pkg::t_div_word o_word,
    input  logic                 i_stall
);
    import htfac_pkg::*;

    logic           r_valid;
    t_div_word      r_word;
    t_div_word      n_word;
    logic [REM_W:0] w_part;
    logic [REM_W:0] w_diff;
    logic           w_bit;

    assign o_stall = r_valid & i_stall;

    // one restoring step: bring in the next dividend bit, try the subtract
    always_comb begin
        w_part = {i_word.rem, i_word.work[NUM_W-1]};
        w_diff = w_part - {1'b0, i_word.divisor};
        w_bit  = (w_part >= {1'b0, i_word.divisor});
        n_word      = i_word;
        n_word.rem  = w_bit ? w_diff[REM_W-1:0] : w_part[REM_W-1:0];
        n_word.work = {i_word.work[NUM_W-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- src/htfac_post.sv -----
module htfac_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  htfac_pkg::t_div_word i_word,
    output logic                 o_stall,
    output logic                 o_valid,
    output logic [16:0]          o_airtime_us,
    input  logic                 i_stall
);
    import htfac_pkg::*;

    logic              r_a_valid;
    logic [QUO_W-1:0]  r_a_quo;
    logic [TIME_W-1:0] r_a_div5;
    logic              r_a_sgi;
    logic [1:0]        r_a_m1;
    logic [TIME_W-1:0] n_a_div5;
    logic              r_b_valid;
    logic [TIME_W-1:0] r_b_time;
    logic [TIME_W-1:0] n_b_time;
    logic              w_b_stall;
    logic [X_W-1:0]    w_x;
    logic [PROD_W-1:0] w_prod;
    logic [TIME_W-1:0] w_sym_us;

    assign w_b_stall = r_b_valid & i_stall;
    assign o_stall   = r_a_valid & w_b_stall;

    // short gi: (n*18+4)/5 through a reciprocal multiply
    always_comb begin
        w_x      = X_W'({i_word.work[QUO_W-1:0], 4'b0000})
                 + X_W'({i_word.work[QUO_W-1:0], 1'b0}) + SGI_ROUND;
        w_prod   = PROD_W'(w_x) * DIV5_RECIP;
        n_a_div5 = w_prod[DIV5_SHIFT +: TIME_W];
    end

    always_comb begin
        w_sym_us = r_a_sgi ? r_a_div5 : TIME_W'({r_a_quo, 2'b00});
        n_b_time = w_sym_us + PREAMBLE_US + LTF_US + TIME_W'({r_a_m1, 2'b00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_a_valid <= i_valid;
            end
            if (!w_b_stall) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_a_quo  <= i_word.work[QUO_W-1:0];
            r_a_div5 <= n_a_div5;
            r_a_sgi  <= i_word.sgi;
            r_a_m1   <= i_word.streams_m1;
        end
        if (!w_b_stall && r_a_valid) begin
            r_b_time <= n_b_time;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_airtime_us = r_b_time;

endmodule

// ----- src/ht_frame_airtime_calc.sv -----
// pipeline: 1 setup stage, 20 divider cells and 2 finish stages from accepted word to result
// throughput: one word per cycle while the output is not stalled; each divider cell resolves one quotient bit per cycle
// a stage takes a new word whenever it is empty or its word moves on, so bubbles close up
// reset (synchronous, active low) clears the valid bit of every stage; data registers are not reset
module ht_frame_airtime_calc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_pkt_length,
    input  logic [4:0]  i_mcs_index,
    input  logic        i_channel_width,
    input  logic        i_short_guard_interval,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_airtime_us
);
    import htfac_pkg::*;

    t_div_word w_word  [NUM_W+1];
    logic      w_valid [NUM_W+1];
    logic      w_stall [NUM_W+1];

    htfac_prep u_prep (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .i_pkt_length           (i_pkt_length),
        .i_mcs_index            (i_mcs_index),
        .i_channel_width        (i_channel_width),
        .i_short_guard_interval (i_short_guard_interval),
        .o_stall                (o_stall),
        .o_valid                (w_valid[0]),
        .o_word                 (w_word[0]),
        .i_stall                (w_stall[0])
    );

    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        htfac_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_word  (w_word[k]),
            .o_stall (w_stall[k]),
            .o_valid (w_valid[k+1]),
            .o_word  (w_word[k+1]),
            .i_stall (w_stall[k+1])
        );
    end

    htfac_post u_post (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NUM_W]),
        .i_word       (w_word[NUM_W]),
        .o_stall      (w_stall[NUM_W]),
        .o_valid      (o_valid),
        .o_airtime_us (o_airtime_us),
        .i_stall      (i_stall)
    );

    // back-pressure reaches the input only when the whole chain is full
    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output not backed up");

    a_airtime_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_airtime_us <= AIRTIME_MAX))
        else $error("airtime above largest possible frame");

    a_airtime_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_airtime_us >= AIRTIME_MIN))
        else $error("airtime below one symbol plus preamble");

endmodule

// ----- test/tb_ht_frame_airtime_calc.sv -----
module tb_ht_frame_airtime_calc;
    import htfac_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int MAX_REPORTED   = 10;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [LEN_W-1:0]     i_pkt_length = '0;
    logic [MCS_W-1:0]     i_mcs_index = '0;
    logic                 i_channel_width = 1'b0;
    logic                 i_short_guard_interval = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [TIME_W-1:0]    o_airtime_us;

    logic [TIME_W-1:0]    airtime_expected_q[$];
    logic [TIME_W-1:0]    airtime_want;
    int                   mismatch_count = 0;
    int                   sender_gap_pct = 0;
    int                   receiver_stall_pct = 0;
    int                   quiet_cycles = 0;

    ht_frame_airtime_calc dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_pkt_length           (i_pkt_length),
        .i_mcs_index            (i_mcs_index),
        .i_channel_width        (i_channel_width),
        .i_short_guard_interval (i_short_guard_interval),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_airtime_us           (o_airtime_us)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // airtime of one ht mixed-format frame in us
    function automatic logic [TIME_W-1:0] ht_airtime_us(input logic [LEN_W-1:0] len,
                                                        input logic [MCS_W-1:0] mcs,
                                                        input logic wide,
                                                        input logic sgi);
        int unsigned n_streams;
        int unsigned data_bits;
        int unsigned bits_one_stream;
        int unsigned bits_per_sym;
        int unsigned n_sym;
        int unsigned total_us;
        n_streams = int'(mcs[4:3]) + 1;
        data_bits = int'(len) * 8 + 22;
        case (mcs[2:0])
            3'd0: bits_one_stream = wide ? 54  : 26;
            3'd1: bits_one_stream = wide ? 108 : 52;
            3'd2: bits_one_stream = wide ? 162 : 78;
            3'd3: bits_one_stream = wide ? 216 : 104;
            3'd4: bits_one_stream = wide ? 324 : 156;
            3'd5: bits_one_stream = wide ? 432 : 208;
            3'd6: bits_one_stream = wide ? 486 : 234;
            default: bits_one_stream = wide ? 540 : 260;
        endcase
        bits_per_sym = bits_one_stream * n_streams;
        n_sym = (data_bits + bits_per_sym - 1) / bits_per_sym;
        // short gi symbols are 3.6 us, rounded up
        total_us = sgi ? (n_sym * 18 + 4) / 5 : n_sym * 4;
        total_us = total_us + 32 + 4 * n_streams;
        return total_us[TIME_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("mismatch: %s expected airtime_us=%0d got %0d", what, want, got);
    endtask

    // receiver side: random stall
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (airtime_expected_q.size() == 0) begin
                note_mismatch("unexpected word,", 'x, o_airtime_us);
            end else begin
                airtime_want = airtime_expected_q.pop_front();
                if (o_airtime_us !== airtime_want)
                    note_mismatch("airtime_us", airtime_want, o_airtime_us);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_frame(input logic [LEN_W-1:0] len, input logic [MCS_W-1:0] mcs,
                              input logic wide, input logic sgi);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid                <= 1'b1;
        i_pkt_length           <= len;
        i_mcs_index            <= mcs;
        i_channel_width        <= wide;
        i_short_guard_interval <= sgi;
        do
            @(posedge i_clk);
        while (o_stall);
        airtime_expected_q.push_back(ht_airtime_us(len, mcs, wide, sgi));
    endtask

    task automatic send_random_frame();
        logic [LEN_W-1:0] len;
        // a quarter of the frames are short to hit the one- and two-symbol cases
        if ($urandom_range(0, 3) == 0)
            len = LEN_W'($urandom_range(0, 64));
        else
            len = LEN_W'($urandom_range(0, 65535));
        send_frame(len, MCS_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (airtime_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_frame_extremes();
        logic [2:0] m;
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        // empty payload still takes one symbol
        send_frame(16'd0, 5'd0, 1'b0, 1'b0);
        send_frame(16'd0, 5'd31, 1'b1, 1'b1);
        // longest payload at several rates, then mixed lengths
        send_frame(16'hFFFF, 5'd0, 1'b0, 1'b0);
        send_frame(16'hFFFF, 5'd0, 1'b0, 1'b1);
        send_frame(16'hFFFF, 5'd31, 1'b1, 1'b1);
        send_frame(16'hFFFF, 5'd31, 1'b0, 1'b0);
        send_frame(16'd1, 5'd7, 1'b1, 1'b0);
        send_frame(16'h5555, 5'b01010, 1'b0, 1'b1);
        send_frame(16'hAAAA, 5'b10101, 1'b1, 1'b0);
        // every modulation, stream count rotating
        for (int k = 0; k < 8; k++) begin
            m = 3'(k);
            send_frame(16'd1500, {2'(k % 4), m}, m[0], m[1]);
        end
        // one to four streams
        for (int s = 0; s < 4; s++)
            send_frame(16'd3, {2'(s), 3'd7}, 1'b1, 1'b1);
    endtask

    task automatic test_pause_until_drained();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        for (int k = 0; k < 12; k++)
            send_random_frame();
        wait_until_drained();
        for (int k = 0; k < 12; k++)
            send_random_frame();
    endtask

    task automatic test_random_frames(input int n_frames, input int gap_pct,
                                      input int stall_pct);
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        for (int k = 0; k < n_frames; k++)
            send_random_frame();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_extremes();
        test_pause_until_drained();
        test_random_frames(460, 28, 76);
        wait_until_drained();
        test_random_frames(460, 76, 28);
        wait_until_drained();
        test_random_frames(470, 0, 0);

        wait_until_drained();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        // catch any stray word after the last one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (airtime_expected_q.size() != 0)
            note_mismatch("missing word,", airtime_expected_q[0], 'x);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
